/* rtl/ftfor_pkg.sv */
// Shared types and constants for the first-touch fill-order remapper.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package ftfor_pkg;

    localparam int ADDR_W       = 48;
    localparam int BLOCK_BYTES  = 64;
    localparam int OFFS_W       = $clog2(BLOCK_BYTES);
    localparam int MAP_BLOCKS   = 4096;
    localparam int IDX_W        = $clog2(MAP_BLOCKS);
    localparam int DEVICE_COUNT = 3;
    localparam int FILL_W       = $clog2(DEVICE_COUNT + 1);
    localparam int SUM_W        = ADDR_W + 2;
    localparam int CFG_IDX_W    = 3;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 56;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV0_BASE = 3'd0,
        CFG_DEV0_SIZE = 3'd1,
        CFG_DEV1_BASE = 3'd2,
        CFG_DEV1_SIZE = 3'd3,
        CFG_DEV2_BASE = 3'd4,
        CFG_DEV2_SIZE = 3'd5
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_NEW   = 2'd1,
        ST_RANGE = 2'd2,
        ST_OOM   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RANGE,
        S_OFFSET,
        S_INDEX,
        S_LOOKUP,
        S_SKIP,
        S_ALLOC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic do_range;
        logic do_offset;
        logic do_index;
        logic do_skip;
        logic do_alloc;
        logic set_hit;
        logic set_fault_range;
        logic set_fault_oom;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_of_range;
        logic valid_hit;
        logic exhausted;
        logic fill_full;
    } t_dp_stat;

endpackage

/* rtl/ftfor_ctrl.sv */
// Controller state machine of the remapper: sequences clear sweep, lookup,
// allocation and result transactions. Depends on ftfor_pkg.
`timescale 1ns / 1ps

module ftfor_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ftfor_pkg::t_dp_cmd  o_cmd,
    input  ftfor_pkg::t_dp_stat i_stat
);
    import ftfor_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_RANGE;
            end
            S_RANGE:  n_state = S_OFFSET;
            S_OFFSET: n_state = S_INDEX;
            S_INDEX: begin
                n_state = i_stat.out_of_range ? S_OUT : S_LOOKUP;
            end
            S_LOOKUP: begin
                n_state = i_stat.valid_hit ? S_OUT : S_SKIP;
            end
            S_SKIP: begin
                priority if (i_stat.exhausted) n_state = S_OUT;
                else if (i_stat.fill_full)     n_state = S_SKIP;
                else                           n_state = S_ALLOC;
            end
            S_ALLOC: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            S_RANGE:  o_cmd.do_range  = 1'b1;
            S_OFFSET: o_cmd.do_offset = 1'b1;
            S_INDEX: begin
                o_cmd.do_index        = !i_stat.out_of_range;
                o_cmd.set_fault_range = i_stat.out_of_range;
            end
            S_LOOKUP: o_cmd.set_hit = i_stat.valid_hit;
            S_SKIP: begin
                o_cmd.set_fault_oom = i_stat.exhausted;
                o_cmd.do_skip       = !i_stat.exhausted && i_stat.fill_full;
            end
            S_ALLOC: o_cmd.do_alloc = 1'b1;
            S_OUT:   o_out_valid    = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output transactions offered together");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("request taken during clear sweep");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> (r_state == S_IDLE))
        else $error("no return to idle after result transaction");
`endif

endmodule

/* rtl/ftfor_datapath.sv */
// Datapath of the remapper: range registers, range match, block index,
// map and valid memories, fill pointers and result register. Depends on ftfor_pkg.
`timescale 1ns / 1ps

module ftfor_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ftfor_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [ftfor_pkg::ADDR_W-1:0]          i_cfg_wdata,
    input  logic [ftfor_pkg::ADDR_W-1:0]          i_req_addr,
    input  ftfor_pkg::t_dp_cmd                    i_cmd,
    output ftfor_pkg::t_dp_stat                   o_stat,
    output logic [ftfor_pkg::ADDR_W-1:0]          o_dev_addr,
    output logic [ftfor_pkg::STATUS_W-1:0]        o_status
);
    import ftfor_pkg::*;

    logic [ADDR_W-1:0]       r_base [DEVICE_COUNT];
    logic [ADDR_W-1:0]       r_size [DEVICE_COUNT];
    logic [ADDR_W-1:0]       r_nfb  [DEVICE_COUNT];
    logic [ADDR_W-1:0]       r_end  [DEVICE_COUNT];
    logic [SUM_W-1:0]        r_taken[DEVICE_COUNT];
    logic [FILL_W-1:0]       r_fill;
    logic [IDX_W-1:0]        r_clr_addr;

    logic [ADDR_W-1:0]       r_req_addr;
    logic [DEVICE_COUNT-1:0] r_match;
    logic                    r_found;
    logic [ADDR_W-1:0]       r_rel;
    logic [SUM_W-1:0]        r_taken_sel;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_valid_rd;
    logic [ADDR_W-1:0]       r_map_rd;
    logic [ADDR_W-1:0]       r_dev_addr;
    t_status                 r_status;

    logic                    r_valid_mem [MAP_BLOCKS];
    logic [ADDR_W-1:0]       r_map_mem   [MAP_BLOCKS];

    logic [ADDR_W:0]         lim      [DEVICE_COUNT];
    logic [SUM_W-1:0]        taken_c  [DEVICE_COUNT];
    logic [DEVICE_COUNT-1:0] match_c;
    logic [ADDR_W-1:0]       aligned;
    logic [ADDR_W-1:0]       offs_ext;
    logic [FILL_W-1:0]       sel_dev;
    logic                    sel_found;
    logic [SUM_W-1:0]        idx_sum;
    logic [IDX_W-1:0]        idx_c;
    logic [FILL_W-1:0]       cfg_dev;
    logic                    cfg_ok;
    logic                    cfg_is_size;
    logic [ADDR_W-1:0]       nfb_sel;
    logic [ADDR_W-1:0]       end_sel;
    logic [ADDR_W:0]         alloc_next;
    logic                    alloc_wrap;
    logic                    valid_we;
    logic [IDX_W-1:0]        valid_waddr;

    assign aligned  = {r_req_addr[ADDR_W-1:OFFS_W], {OFFS_W{1'b0}}};
    assign offs_ext = {{(ADDR_W-OFFS_W){1'b0}}, r_req_addr[OFFS_W-1:0]};

    // range limits, collapsed offsets and match flags
    always_comb begin
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            lim[d]     = {1'b0, r_base[d]} + {1'b0, r_size[d]};
            match_c[d] = (r_size[d] != '0) && (aligned >= r_base[d])
                         && ({1'b0, aligned} < lim[d]);
        end
        taken_c[0] = '0;
        for (int d = 1; d < DEVICE_COUNT; d++) begin
            taken_c[d] = taken_c[d-1] + {2'b00, r_size[d-1]};
        end
    end

    // first matching device wins
    always_comb begin
        sel_dev   = '0;
        sel_found = 1'b0;
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            if (r_match[d] && !sel_found) begin
                sel_found = 1'b1;
                sel_dev   = FILL_W'(d);
            end
        end
    end

    assign idx_sum = r_taken_sel + {2'b00, r_rel};
    assign idx_c   = idx_sum[OFFS_W+IDX_W-1:OFFS_W];

    assign cfg_dev     = i_cfg_addr[CFG_IDX_W-1:1];
    assign cfg_is_size = i_cfg_addr[0];
    assign cfg_ok      = (i_cfg_addr <= CFG_DEV2_SIZE)
                         && (cfg_dev < FILL_W'(DEVICE_COUNT));

    assign nfb_sel    = r_nfb[r_fill];
    assign end_sel    = r_end[r_fill];
    assign alloc_next = {1'b0, nfb_sel} + (ADDR_W+1)'(BLOCK_BYTES);
    assign alloc_wrap = alloc_next >= {1'b0, end_sel};

    assign o_stat.clr_last     = &r_clr_addr;
    assign o_stat.out_of_range = !r_found || (|idx_sum[SUM_W-1:OFFS_W+IDX_W]);
    assign o_stat.valid_hit    = r_valid_rd;
    assign o_stat.exhausted    = r_fill >= FILL_W'(DEVICE_COUNT);
    assign o_stat.fill_full    = !o_stat.exhausted && (nfb_sel >= end_sel);

    // range registers, fill pointers and derived limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_base[d]  <= '0;
                r_size[d]  <= '0;
                r_nfb[d]   <= '0;
                r_end[d]   <= '0;
                r_taken[d] <= '0;
            end
            r_fill     <= '0;
            r_clr_addr <= '0;
        end else begin
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_end[d]   <= lim[d][ADDR_W] ? ADDR_MAX : lim[d][ADDR_W-1:0];
                r_taken[d] <= taken_c[d];
            end
            if (i_cfg_we && cfg_ok) begin
                if (cfg_is_size) begin
                    r_size[cfg_dev] <= i_cfg_wdata;
                    r_nfb[cfg_dev]  <= r_base[cfg_dev];
                end else begin
                    r_base[cfg_dev] <= i_cfg_wdata;
                    r_nfb[cfg_dev]  <= i_cfg_wdata;
                end
            end
            if (i_cmd.do_skip) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.do_alloc) begin
                if (alloc_wrap) begin
                    r_nfb[r_fill] <= end_sel;
                    r_fill        <= r_fill + 1'b1;
                end else begin
                    r_nfb[r_fill] <= alloc_next[ADDR_W-1:0];
                end
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // request pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) r_req_addr <= i_req_addr;
        if (i_cmd.do_range) r_match    <= match_c;
        if (i_cmd.do_offset) begin
            r_found     <= sel_found;
            r_rel       <= aligned - r_base[sel_dev];
            r_taken_sel <= r_taken[sel_dev];
        end
        if (i_cmd.do_index) r_idx <= idx_c;
    end

    assign valid_we    = i_cmd.clr_step || i_cmd.do_alloc;
    assign valid_waddr = i_cmd.clr_step ? r_clr_addr : r_idx;

    always_ff @(posedge i_clk) begin
        if (valid_we) r_valid_mem[valid_waddr] <= !i_cmd.clr_step;
        if (i_cmd.do_index) r_valid_rd <= r_valid_mem[idx_c];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_alloc) r_map_mem[r_idx] <= nfb_sel;
        if (i_cmd.do_index) r_map_rd <= r_map_mem[idx_c];
    end

    // result register
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.set_hit) begin
            r_dev_addr <= r_map_rd + offs_ext;
            r_status   <= ST_HIT;
        end else if (i_cmd.do_alloc) begin
            r_dev_addr <= nfb_sel + offs_ext;
            r_status   <= ST_NEW;
        end else if (i_cmd.set_fault_range) begin
            r_dev_addr <= '0;
            r_status   <= ST_RANGE;
        end else if (i_cmd.set_fault_oom) begin
            r_dev_addr <= '0;
            r_status   <= ST_OOM;
        end
    end

    assign o_dev_addr = r_dev_addr;
    assign o_status   = r_status;

`ifndef ASSERT_OFF
    a_fill_monotonic: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> (r_fill >= $past(r_fill)))
        else $error("fill device moved backwards");

    a_alloc_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_alloc |-> (!o_stat.exhausted && !o_stat.fill_full))
        else $error("allocation from a full or missing device");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set_fault_range || i_cmd.set_fault_oom) |=> (r_dev_addr == '0))
        else $error("fault result carries a nonzero address");
`endif

endmodule

/* rtl/first_touch_fill_order_remap.sv */
// Top level of the first-touch fill-order remapper.
// Instantiates ftfor_ctrl and ftfor_datapath; depends on ftfor_pkg.
`timescale 1ns / 1ps

// After reset the block sweeps its 4096-entry valid table and takes no request
// meanwhile; configuration writes are accepted throughout.
// Requests are handled one at a time. Each passes in turn through the range
// match, the offset and block index step with its registered map and valid
// memory read, and the lookup; an address outside every range is answered
// after the index step. A block not yet mapped goes on to the fill-device walk,
// which passes over each full or absent device in turn and then allocates, or
// reports out of memory once every device is passed. Write ranges only while no
// request is in flight.

module first_touch_fill_order_remap (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // request_address[47:0]
    input  logic [ftfor_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // device_address[47:0], status[49:48], zero pad[55:50]
    output logic [ftfor_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [ftfor_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [ftfor_pkg::ADDR_W-1:0]        i_cfg_wdata
);
    import ftfor_pkg::*;

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic [ADDR_W-1:0]   dev_addr;
    logic [STATUS_W-1:0] status;

    ftfor_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ftfor_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_addr  (s_axis_tdata[ADDR_W-1:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_dev_addr  (dev_addr),
        .o_status    (status)
    );

    assign m_axis_tdata = {{(M_TDATA_W-ADDR_W-STATUS_W){1'b0}}, status, dev_addr};

endmodule
